// ===== rtl/core/pss_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package pss_pkg;

  localparam int CFG_W          = 17;
  localparam int CFG_IDX_W      = 1;
  localparam int WORD_W         = 31;
  localparam int VALUE_W        = 16;
  localparam int POS_OUT_W      = 16;
  localparam int STATUS_W       = 2;
  localparam int DRAW_POS_W     = 17;
  localparam int EPOCH_W        = 8;
  localparam int POOL_DEPTH_DEF = 65536;

  localparam logic [CFG_W-1:0] CFG_RESET = 17'h10000;

  localparam logic [CFG_IDX_W-1:0] REG_POOL_SIZE    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_COUNT = 1'd1;

  localparam logic OP_DRAW    = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  localparam logic [STATUS_W-1:0] ST_VALUE     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RESTART   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 2'd2;

endpackage
`default_nettype wire

// ===== rtl/core/pss_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface pss_in_if;
  logic                       valid;
  logic                       ready;
  logic                       opcode;
  logic [pss_pkg::WORD_W-1:0] random_word;

  modport source (output valid, output opcode, output random_word, input ready);
  modport sink   (input valid, input opcode, input random_word, output ready);
endinterface

interface pss_out_if;
  logic                          valid;
  logic                          ready;
  logic [pss_pkg::VALUE_W-1:0]   value;
  logic [pss_pkg::POS_OUT_W-1:0] position;
  logic                          last;
  logic [pss_pkg::STATUS_W-1:0]  status;

  modport source (output valid, output value, output position, output last,
                  output status, input ready);
  modport sink   (input valid, input value, input position, input last,
                  input status, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/pss_mod.sv =====
`timescale 1ns / 1ps
`default_nettype none
module pss_mod #(
  parameter int NW = 17
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [pss_pkg::WORD_W-1:0] dividend,
  input  wire logic [NW-1:0]              divisor,
  output logic                            done,
  output logic [NW-1:0]                   rem
);

  localparam int CW = $clog2(pss_pkg::WORD_W);

  logic [pss_pkg::WORD_W-1:0] dvd_r, dvd_nxt;
  logic [NW-1:0]              dsr_r, dsr_nxt;
  logic [NW-1:0]              rem_r, rem_nxt;
  logic [CW-1:0]              cnt_r, cnt_nxt;
  logic                       busy_r, busy_nxt;
  logic                       done_r, done_nxt;
  logic [NW:0]                trial;
  logic [NW:0]                diff;

  assign trial = {rem_r, dvd_r[pss_pkg::WORD_W-1]};
  assign diff  = trial - {1'b0, dsr_r};

  always_comb begin
    dvd_nxt  = dvd_r;
    dsr_nxt  = dsr_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      dvd_nxt  = dividend;
      dsr_nxt  = divisor;
      rem_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // restoring step: one dividend bit per cycle
      rem_nxt = (trial >= {1'b0, dsr_r}) ? diff[NW-1:0] : trial[NW-1:0];
      dvd_nxt = {dvd_r[pss_pkg::WORD_W-2:0], 1'b0};
      cnt_nxt = cnt_r + CW'(1);
      if (cnt_r == CW'(pss_pkg::WORD_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    dsr_r <= dsr_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule
`default_nettype wire

// ===== rtl/core/pss_pool.sv =====
`timescale 1ns / 1ps
`default_nettype none
module pss_pool #(
  parameter int DEPTH = 65536,
  parameter int AW    = 16,
  parameter int DW    = 24
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] addr,
  input  wire logic [DW-1:0] wdata,
  output logic [DW-1:0]      rdata
);

  logic [DW-1:0] store_r [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      store_r[addr] <= wdata;
    end
    rdata_r <= store_r[addr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// ===== rtl/core/partial_shuffle_sampler_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Partial Fisher-Yates sampler: draws distinct values from 0..pool_size-1.
// in_chan: valid/ready transfer of {opcode, random_word}; opcode draw or restart.
// out_chan: valid/ready transfer of {value, position, last, status}, one per item.
// cfg_we/cfg_index/cfg_wdata: write pool_size (index 0) or sample_count (index 1)
// while the block is idle; both reset to 65536.
// A draw passes through a check state, the bit-serial remainder unit (one
// random_word bit per cycle, then its done flag), four accesses to the
// single-port pool memory and a load of the output register. An exhausted draw,
// and a restart that starts no clearing pass, give their result from the check state.
// One item is in flight at a time; in_chan.ready is high only while waiting.
// Pool entries carry an epoch mark; a restart bumps the epoch. After reset, and
// on every 255th restart, a clearing pass writes every entry, during which no
// item is taken (configuration writes still are).
// The finished result sits in the output register until taken; the next item
// is accepted meanwhile, and its result waits until the register is free.
module partial_shuffle_sampler_core #(
  parameter int POOL_DEPTH = pss_pkg::POOL_DEPTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [pss_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [pss_pkg::CFG_W-1:0]     cfg_wdata,
  pss_in_if.sink                             in_chan,
  pss_out_if.source                          out_chan
);

  localparam int AW  = $clog2(POOL_DEPTH);
  localparam int NW  = (AW + 1 > pss_pkg::CFG_W) ? AW + 1 : pss_pkg::CFG_W;
  localparam int VW  = pss_pkg::VALUE_W;
  localparam int EW  = pss_pkg::EPOCH_W;
  localparam int PW  = pss_pkg::DRAW_POS_W;
  localparam int EDW = EW + VW;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_CHECK, S_DIV, S_RD_A, S_RD_B, S_WR_A, S_WR_B
  } state_t;

  state_t                          state_r, state_nxt;
  logic                            done_st_r, done_st_nxt;
  logic [pss_pkg::CFG_W-1:0]       pool_size_r, pool_size_nxt;
  logic [pss_pkg::CFG_W-1:0]       sample_count_r, sample_count_nxt;
  logic [NW-1:0]                   n_r, n_nxt;
  logic [NW-1:0]                   limit_r, limit_nxt;
  logic [PW-1:0]                   draw_pos_r, draw_pos_nxt;
  logic [EW-1:0]                   epoch_r, epoch_nxt;
  logic [AW-1:0]                   clr_addr_r, clr_addr_nxt;
  logic                            pend_r, pend_nxt;
  logic                            op_r, op_nxt;
  logic [pss_pkg::WORD_W-1:0]      word_r, word_nxt;
  logic [NW-1:0]                   pos_r, pos_nxt;
  logic [NW-1:0]                   j_r, j_nxt;
  logic [VW-1:0]                   a_val_r, a_val_nxt;
  logic [VW-1:0]                   res_value_r, res_value_nxt;
  logic [pss_pkg::POS_OUT_W-1:0]   res_pos_r, res_pos_nxt;
  logic                            res_last_r, res_last_nxt;
  logic [pss_pkg::STATUS_W-1:0]    res_status_r, res_status_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic [VW-1:0]                   out_value_r, out_value_nxt;
  logic [pss_pkg::POS_OUT_W-1:0]   out_pos_r, out_pos_nxt;
  logic                            out_last_r, out_last_nxt;
  logic [pss_pkg::STATUS_W-1:0]    out_status_r, out_status_nxt;

  logic            mod_start;
  logic [NW-1:0]   mod_divisor;
  logic            mod_done;
  logic [NW-1:0]   mod_rem;
  logic            pool_we;
  logic [AW-1:0]   pool_addr;
  logic [EDW-1:0]  pool_wdata;
  logic [EDW-1:0]  pool_rdata;
  logic [NW-1:0]   pos_ext;
  logic [VW-1:0]   b_val;
  logic            in_xfer;

  function automatic logic [VW-1:0] entry_value(input logic [EDW-1:0] e,
                                                input logic [EW-1:0]  ep,
                                                input logic [NW-1:0]  idx);
    logic [VW-1:0] v;
    if (e[EDW-1:VW] == ep) begin
      v = e[VW-1:0];
    end else begin
      v = idx[VW-1:0];
    end
    return v;
  endfunction

  pss_mod #(
    .NW (NW)
  ) u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .dividend (word_r),
    .divisor  (mod_divisor),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  pss_pool #(
    .DEPTH (POOL_DEPTH),
    .AW    (AW),
    .DW    (EDW)
  ) u_pool (
    .clk   (clk),
    .we    (pool_we),
    .addr  (pool_addr),
    .wdata (pool_wdata),
    .rdata (pool_rdata)
  );

  assign in_xfer     = in_chan.valid && (state_r == S_IDLE) && !done_st_r;
  assign pos_ext     = NW'(draw_pos_r);
  assign mod_divisor = n_r - pos_ext;
  assign b_val       = entry_value(pool_rdata, epoch_r, j_r);

  always_comb begin
    state_nxt        = state_r;
    done_st_nxt      = done_st_r;
    pool_size_nxt    = pool_size_r;
    sample_count_nxt = sample_count_r;
    draw_pos_nxt     = draw_pos_r;
    epoch_nxt        = epoch_r;
    clr_addr_nxt     = clr_addr_r;
    pend_nxt         = pend_r;
    op_nxt           = op_r;
    word_nxt         = word_r;
    pos_nxt          = pos_r;
    j_nxt            = j_r;
    a_val_nxt        = a_val_r;
    res_value_nxt    = res_value_r;
    res_pos_nxt      = res_pos_r;
    res_last_nxt     = res_last_r;
    res_status_nxt   = res_status_r;
    out_valid_nxt    = out_valid_r;
    out_value_nxt    = out_value_r;
    out_pos_nxt      = out_pos_r;
    out_last_nxt     = out_last_r;
    out_status_nxt   = out_status_r;
    mod_start        = 1'b0;
    pool_we          = 1'b0;
    pool_addr        = pos_r[AW-1:0];
    pool_wdata       = '0;

    if (cfg_we) begin
      case (cfg_index)
        pss_pkg::REG_POOL_SIZE:    pool_size_nxt    = cfg_wdata;
        pss_pkg::REG_SAMPLE_COUNT: sample_count_nxt = cfg_wdata;
        default: ;
      endcase
    end

    n_nxt     = (NW'(pool_size_nxt) > NW'(POOL_DEPTH)) ? NW'(POOL_DEPTH)
                                                       : NW'(pool_size_nxt);
    limit_nxt = (NW'(sample_count_nxt) < n_nxt) ? NW'(sample_count_nxt) : n_nxt;

    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    if (done_st_r) begin
      // hand the result over once the output register is free
      if (!out_valid_r || out_chan.ready) begin
        out_valid_nxt  = 1'b1;
        out_value_nxt  = res_value_r;
        out_pos_nxt    = res_pos_r;
        out_last_nxt   = res_last_r;
        out_status_nxt = res_status_r;
        done_st_nxt    = 1'b0;
      end
    end

    case (state_r)
      S_CLEAR: begin
        pool_we      = 1'b1;
        pool_addr    = clr_addr_r;
        pool_wdata   = '0;
        clr_addr_nxt = clr_addr_r + AW'(1);
        if (clr_addr_r == AW'(POOL_DEPTH - 1)) begin
          clr_addr_nxt = '0;
          epoch_nxt    = EW'(1);
          state_nxt    = S_IDLE;
          if (pend_r) begin
            pend_nxt    = 1'b0;
            done_st_nxt = 1'b1;
          end
        end
      end
      S_IDLE: begin
        if (in_xfer) begin
          op_nxt    = in_chan.opcode;
          word_nxt  = in_chan.random_word;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (op_r == pss_pkg::OP_RESTART) begin
          draw_pos_nxt   = '0;
          res_value_nxt  = '0;
          res_pos_nxt    = '0;
          res_last_nxt   = 1'b0;
          res_status_nxt = pss_pkg::ST_RESTART;
          if (epoch_r == {EW{1'b1}}) begin
            pend_nxt  = 1'b1;
            state_nxt = S_CLEAR;
          end else begin
            epoch_nxt   = epoch_r + EW'(1);
            done_st_nxt = 1'b1;
            state_nxt   = S_IDLE;
          end
        end else if (pos_ext >= limit_r) begin
          res_value_nxt  = '0;
          res_pos_nxt    = draw_pos_r[pss_pkg::POS_OUT_W-1:0];
          res_last_nxt   = 1'b0;
          res_status_nxt = pss_pkg::ST_EXHAUSTED;
          done_st_nxt    = 1'b1;
          state_nxt      = S_IDLE;
        end else begin
          mod_start      = 1'b1;
          pos_nxt        = pos_ext;
          res_pos_nxt    = draw_pos_r[pss_pkg::POS_OUT_W-1:0];
          res_last_nxt   = ((pos_ext + NW'(1)) == limit_r);
          res_status_nxt = pss_pkg::ST_VALUE;
          draw_pos_nxt   = draw_pos_r + PW'(1);
          state_nxt      = S_DIV;
        end
      end
      S_DIV: begin
        if (mod_done) begin
          j_nxt     = pos_r + mod_rem;
          state_nxt = S_RD_A;
        end
      end
      S_RD_A: begin
        pool_addr = pos_r[AW-1:0];
        state_nxt = S_RD_B;
      end
      S_RD_B: begin
        pool_addr = j_r[AW-1:0];
        a_val_nxt = entry_value(pool_rdata, epoch_r, pos_r);
        state_nxt = S_WR_A;
      end
      S_WR_A: begin
        pool_we       = 1'b1;
        pool_addr     = pos_r[AW-1:0];
        pool_wdata    = {epoch_r, b_val};
        res_value_nxt = b_val;
        state_nxt     = S_WR_B;
      end
      S_WR_B: begin
        pool_we     = 1'b1;
        pool_addr   = j_r[AW-1:0];
        pool_wdata  = {epoch_r, a_val_r};
        done_st_nxt = 1'b1;
        state_nxt   = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_CLEAR;
      done_st_r      <= 1'b0;
      pool_size_r    <= pss_pkg::CFG_RESET;
      sample_count_r <= pss_pkg::CFG_RESET;
      draw_pos_r     <= '0;
      epoch_r        <= EW'(1);
      clr_addr_r     <= '0;
      pend_r         <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      done_st_r      <= done_st_nxt;
      pool_size_r    <= pool_size_nxt;
      sample_count_r <= sample_count_nxt;
      draw_pos_r     <= draw_pos_nxt;
      epoch_r        <= epoch_nxt;
      clr_addr_r     <= clr_addr_nxt;
      pend_r         <= pend_nxt;
      out_valid_r    <= out_valid_nxt;
    end
    n_r          <= n_nxt;
    limit_r      <= limit_nxt;
    op_r         <= op_nxt;
    word_r       <= word_nxt;
    pos_r        <= pos_nxt;
    j_r          <= j_nxt;
    a_val_r      <= a_val_nxt;
    res_value_r  <= res_value_nxt;
    res_pos_r    <= res_pos_nxt;
    res_last_r   <= res_last_nxt;
    res_status_r <= res_status_nxt;
    out_value_r  <= out_value_nxt;
    out_pos_r    <= out_pos_nxt;
    out_last_r   <= out_last_nxt;
    out_status_r <= out_status_nxt;
  end

  assign in_chan.ready     = (state_r == S_IDLE) && !done_st_r;
  assign out_chan.valid    = out_valid_r;
  assign out_chan.value    = out_value_r;
  assign out_chan.position = out_pos_r;
  assign out_chan.last     = out_last_r;
  assign out_chan.status   = out_status_r;

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
module tb;

  localparam int unsigned DEPTH       = pss_pkg::POOL_DEPTH_DEF;
  localparam int          RAND_ITEMS  = 1800;
  localparam int          STALL_LIMIT = 200000;
  localparam int          HOLD_CYCLES = 300;

  typedef struct packed {
    logic [pss_pkg::VALUE_W-1:0]   value;
    logic [pss_pkg::POS_OUT_W-1:0] position;
    logic                          last;
    logic [pss_pkg::STATUS_W-1:0]  status;
  } draw_result_t;

  class draw_scoreboard;
    logic [pss_pkg::CFG_W-1:0]      pool_size;
    logic [pss_pkg::CFG_W-1:0]      sample_count;
    logic [pss_pkg::DRAW_POS_W-1:0] draw_pos;
    logic [pss_pkg::VALUE_W-1:0]    shuffled [int unsigned];
    draw_result_t                   expected_q [$];
    int                             errors;

    function new();
      pool_size    = pss_pkg::CFG_RESET;
      sample_count = pss_pkg::CFG_RESET;
      draw_pos     = '0;
      errors       = 0;
    endfunction

    function void set_reg(logic [pss_pkg::CFG_IDX_W-1:0] idx,
                          logic [pss_pkg::CFG_W-1:0] data);
      if (idx == pss_pkg::REG_POOL_SIZE) pool_size = data;
      else if (idx == pss_pkg::REG_SAMPLE_COUNT) sample_count = data;
    endfunction

    function int unsigned entry_at(int unsigned idx);
      if (shuffled.exists(idx)) return shuffled[idx];
      return idx;
    endfunction

    function int unsigned draw_limit();
      int unsigned n;
      n = (pool_size > DEPTH) ? DEPTH : pool_size;
      return (sample_count < n) ? sample_count : n;
    endfunction

    function void note_item(logic op, logic [pss_pkg::WORD_W-1:0] word);
      draw_result_t r;
      int unsigned  n, lim, pos, j, a, b, pos_next;
      r = '0;
      if (op == pss_pkg::OP_RESTART) begin
        shuffled.delete();
        draw_pos = '0;
        r.status = pss_pkg::ST_RESTART;
      end else begin
        n   = (pool_size > DEPTH) ? DEPTH : pool_size;
        lim = draw_limit();
        pos = int'(draw_pos);
        if (pos >= lim) begin
          r.position = pos[pss_pkg::POS_OUT_W-1:0];
          r.status   = pss_pkg::ST_EXHAUSTED;
        end else begin
          j = pos + int'(word) % (n - pos);
          a = entry_at(pos);
          b = entry_at(j);
          shuffled[pos] = b[pss_pkg::VALUE_W-1:0];
          shuffled[j]   = a[pss_pkg::VALUE_W-1:0];
          pos_next   = pos + 1;
          draw_pos   = pos_next[pss_pkg::DRAW_POS_W-1:0];
          r.value    = b[pss_pkg::VALUE_W-1:0];
          r.position = pos[pss_pkg::POS_OUT_W-1:0];
          r.last     = (pos_next == lim);
          r.status   = pss_pkg::ST_VALUE;
        end
      end
      expected_q.push_back(r);
    endfunction

    function void check_field(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      end
    endfunction

    function void check_result(draw_result_t got);
      draw_result_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: result with none expected, actual value %0d position %0d",
                 $time, got.value, got.position);
        $display("%0t: unexpected result, actual last %0b status %0d",
                 $time, got.last, got.status);
        return;
      end
      want = expected_q.pop_front();
      check_field("value", 32'(want.value), 32'(got.value));
      check_field("position", 32'(want.position), 32'(got.position));
      check_field("last", 32'(want.last), 32'(got.last));
      check_field("status", 32'(want.status), 32'(got.status));
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                          clk = 1'b0;
  logic                          rst_n;
  logic                          cfg_we;
  logic [pss_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [pss_pkg::CFG_W-1:0]     cfg_wdata;

  pss_in_if  in_if ();
  pss_out_if out_if ();

  draw_scoreboard sb;
  bit             no_gaps;
  bit             hold_req;
  int             items_sent;
  int             quiet_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  partial_shuffle_sampler_core #(.POOL_DEPTH(DEPTH)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_chan   (in_if),
    .out_chan  (out_if)
  );

  function automatic int idle_len();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 70);
  endfunction

  function automatic logic [pss_pkg::WORD_W-1:0] rand_word();
    int          r;
    logic [31:0] w;
    r = $urandom_range(19);
    if (r == 0) return '0;
    if (r == 1) return '1;
    if (r < 5) w = $urandom_range(15);
    else w = $urandom();
    return w[pss_pkg::WORD_W-1:0];
  endfunction

  task automatic send_item(input logic op, input logic [pss_pkg::WORD_W-1:0] word);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.opcode      <= op;
    in_if.random_word <= word;
    do @(posedge clk); while (!(in_if.valid && in_if.ready));
    sb.note_item(op, word);
    items_sent++;
  endtask

  // drop valid and wait for the block to drain
  task automatic settle();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [pss_pkg::CFG_IDX_W-1:0] idx,
                           input logic [pss_pkg::CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    sb.set_reg(idx, data);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    int          sess, r, sel, n_draws, start_items;
    int unsigned ps, sc, lim, left;
    sb = new();
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = pss_pkg::REG_POOL_SIZE;
    cfg_wdata         = '0;
    in_if.valid       = 1'b0;
    in_if.opcode      = pss_pkg::OP_DRAW;
    in_if.random_word = '0;
    no_gaps           = 1'b0;
    hold_req          = 1'b0;
    items_sent        = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    send_item(pss_pkg::OP_DRAW, '0);
    send_item(pss_pkg::OP_DRAW, '1);
    send_item(pss_pkg::OP_DRAW, rand_word());
    send_item(pss_pkg::OP_DRAW, rand_word());
    send_item(pss_pkg::OP_RESTART, '1);
    settle();
    write_reg(pss_pkg::REG_POOL_SIZE, 17'd1);
    write_reg(pss_pkg::REG_SAMPLE_COUNT, '1);
    send_item(pss_pkg::OP_RESTART, '0);
    send_item(pss_pkg::OP_DRAW, '1);
    send_item(pss_pkg::OP_DRAW, '0);
    settle();
    write_reg(pss_pkg::REG_POOL_SIZE, '0);
    send_item(pss_pkg::OP_DRAW, rand_word());
    settle();
    write_reg(pss_pkg::REG_POOL_SIZE, '1);
    write_reg(pss_pkg::REG_SAMPLE_COUNT, 17'd3);
    send_item(pss_pkg::OP_RESTART, '0);
    repeat (4) send_item(pss_pkg::OP_DRAW, '1);
    settle();
    write_reg(pss_pkg::REG_SAMPLE_COUNT, '0);
    send_item(pss_pkg::OP_DRAW, '0);
    settle();
    write_reg(pss_pkg::REG_POOL_SIZE, 17'd8);
    write_reg(pss_pkg::REG_SAMPLE_COUNT, 17'd8);
    send_item(pss_pkg::OP_RESTART, rand_word());
    repeat (3) send_item(pss_pkg::OP_DRAW, rand_word());
    settle();
    write_reg(pss_pkg::REG_SAMPLE_COUNT, 17'd2);
    send_item(pss_pkg::OP_DRAW, rand_word());
    settle();
    write_reg(pss_pkg::REG_SAMPLE_COUNT, 17'd5);
    repeat (3) send_item(pss_pkg::OP_DRAW, rand_word());

    sess        = 0;
    start_items = items_sent;
    while (items_sent - start_items < RAND_ITEMS) begin
      settle();
      r = $urandom_range(99);
      if (r < 60) ps = $urandom_range(1, 64);
      else if (r < 72) ps = $urandom_range(65, 4096);
      else if (r < 80) ps = DEPTH;
      else if (r < 87) ps = $urandom_range(DEPTH + 1, 131071);
      else if (r < 93) ps = 0;
      else ps = $urandom_range(1, 3);
      r = $urandom_range(99);
      if (r < 55) sc = $urandom_range(1, 32);
      else if (r < 65) sc = $urandom_range(33, 200);
      else if (r < 75) sc = 0;
      else if (r < 85) sc = 131071;
      else if (r < 92) sc = DEPTH;
      else sc = 1;
      sel = $urandom_range(3);
      if (sel != 2) write_reg(pss_pkg::REG_POOL_SIZE, ps[pss_pkg::CFG_W-1:0]);
      if (sel != 1) write_reg(pss_pkg::REG_SAMPLE_COUNT, sc[pss_pkg::CFG_W-1:0]);

      no_gaps = (sess % 6 == 5);
      if ($urandom_range(99) < 85) send_item(pss_pkg::OP_RESTART, rand_word());
      lim     = sb.draw_limit();
      left    = (lim > sb.draw_pos) ? lim - sb.draw_pos : 0;
      n_draws = (left > 60) ? $urandom_range(20, 60) : left;
      n_draws += $urandom_range(2);
      // hold the receiver off while the sender keeps offering
      if (sess % 25 == 3) begin
        hold_req = 1'b1;
        if (n_draws < 12) n_draws = 12;
      end
      repeat (n_draws) begin
        if ($urandom_range(99) < 4)
          send_item(($urandom_range(1) == 1) ? pss_pkg::OP_RESTART : pss_pkg::OP_DRAW,
                    rand_word());
        else send_item(pss_pkg::OP_DRAW, rand_word());
      end
      sess++;
    end

    settle();
    repeat (50) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  initial begin
    int gap;
    out_if.ready = 1'b0;
    do @(posedge clk); while (rst_n !== 1'b1);
    forever begin
      if (hold_req) begin
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        gap = idle_len();
        if (gap > 0) begin
          out_if.ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!(out_if.valid && out_if.ready));
    end
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_if.valid && out_if.ready)
      sb.check_result({out_if.value, out_if.position, out_if.last, out_if.status});
  end

  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
